// ===== rtl/spot_light_incident_scale_core_defines.svh =====
// Assertion macros used by the checker file of the spot light scale core.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef SPOT_LIGHT_INCIDENT_SCALE_CORE_DEFINES_SVH
`define SPOT_LIGHT_INCIDENT_SCALE_CORE_DEFINES_SVH

// Concurrent assertion with a caller-supplied message.
`define SLIS_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent assertion with a generic message.
`define SLIS_ASSERT(lbl, prop) \
    `SLIS_ASSERT_MSG(lbl, prop, "spot light scale core check failed")

`endif

// ===== rtl/slis_pkg.sv =====
// Shared widths, register codes, reset values and sideband types of the
// spot light incident scale core. No dependencies.
`default_nettype none

package slis_pkg;

    localparam int unsigned PosW      = 32;
    localparam int unsigned AxW       = 16;
    localparam int unsigned DirW      = 16;
    localparam int unsigned DirFracW  = 14;
    localparam int unsigned FallW     = 15;
    localparam int unsigned ScaleW    = 32;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 32;
    localparam int unsigned DiffW     = 33;
    localparam int unsigned AbsW      = 32;
    localparam int unsigned AbsPosW   = 5;
    localparam int unsigned NormW     = 30;
    localparam int unsigned SqW       = 60;
    localparam int unsigned SumW      = 62;
    localparam int unsigned RootW     = 31;
    localparam int unsigned AdW       = 25;
    localparam int unsigned AdSqW     = 50;
    localparam int unsigned DdW       = 52;
    localparam int unsigned NumW      = 45;
    localparam int unsigned DivQW     = 15;
    localparam int unsigned DivRemW   = 31;
    localparam int unsigned ProdW     = 32;
    localparam int unsigned C28W      = 34;
    localparam int unsigned ScaleQW   = 32;

    localparam logic [FallW-1:0] FallOne    = 15'd16384;
    localparam logic [AxW-1:0]   AxisZRst   = 16'd16384;
    localparam logic [AxW-1:0]   CosFullRst = 16'd14115;
    localparam logic [AxW-1:0]   CosEdgeRst = 16'd14189;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LIGHT_POS_X,
        CFG_LIGHT_POS_Y,
        CFG_LIGHT_POS_Z,
        CFG_AXIS_X,
        CFG_AXIS_Y,
        CFG_AXIS_Z,
        CFG_COS_FULL,
        CFG_COS_EDGE
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0][NormW-1:0] an;
        logic [2:0]            neg;
        logic                  degen;
        logic                  big;
        logic [DdW-1:0]        dd;
    } t_sqrt_side;

    typedef struct packed {
        logic [2:0]     neg;
        logic           degen;
        logic           big;
        logic [DdW-1:0] dd;
    } t_ddiv_side;

    typedef struct packed {
        logic [2:0][DirW-1:0] dir;
        logic                 degen;
        logic                 big;
        logic [DdW-1:0]       dd;
        logic                 fix;
        logic                 fix_one;
    } t_fdiv_side;

    typedef struct packed {
        logic [2:0][DirW-1:0] dir;
        logic [FallW-1:0]     fall;
        logic                 degen;
        logic                 sat;
        logic                 zero;
    } t_sdiv_side;

endpackage

`default_nettype wire

// ===== rtl/slis_pt_if.sv =====
// Input channel of the spot light scale core: one shading point per word.
// Depends on slis_pkg for the field widths.
`default_nettype none

interface slis_pt_if;
    logic                              valid;
    logic                              ready;
    logic signed [slis_pkg::PosW-1:0]  point_x;
    logic signed [slis_pkg::PosW-1:0]  point_y;
    logic signed [slis_pkg::PosW-1:0]  point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/slis_res_if.sv =====
// Result channel of the spot light scale core: direction, falloff and scale.
// Depends on slis_pkg for the field widths.
`default_nettype none

interface slis_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [slis_pkg::DirW-1:0]  dir_x;
    logic signed [slis_pkg::DirW-1:0]  dir_y;
    logic signed [slis_pkg::DirW-1:0]  dir_z;
    logic [slis_pkg::FallW-1:0]        falloff;
    logic [slis_pkg::ScaleW-1:0]       light_scale;
    logic                              degenerate;

    modport source (output valid, output dir_x, output dir_y, output dir_z,
                    output falloff, output light_scale, output degenerate,
                    input ready);
    modport sink (input valid, input dir_x, input dir_y, input dir_z,
                  input falloff, input light_scale, input degenerate,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/slis_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on slis_pkg for the operand and root widths.
`default_nettype none

module slis_sqrt #(
    parameter int unsigned SW = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [slis_pkg::SumW-1:0]     i_x,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_vld,
    output logic [slis_pkg::RootW-1:0]    o_root,
    output logic [SW-1:0]                 o_side
);
    localparam int unsigned XW  = slis_pkg::SumW;
    localparam int unsigned RtW = slis_pkg::RootW;
    localparam int unsigned RmW = RtW + 2;
    localparam int unsigned TW  = RmW + 2;

    logic           r_vld  [RtW];
    logic [XW-1:0]  r_x    [RtW];
    logic [RmW-1:0] r_rem  [RtW];
    logic [RtW-1:0] r_root [RtW];
    logic [SW-1:0]  r_side [RtW];

    for (genvar k = 0; k < RtW; k++) begin : g_stage
        logic           w_vld;
        logic [XW-1:0]  w_x;
        logic [RmW-1:0] w_rem;
        logic [RtW-1:0] w_root;
        logic [SW-1:0]  w_side;
        logic [TW-1:0]  w_t;
        logic [TW-1:0]  w_trial;
        logic           w_ge;
        logic [RmW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_x    = i_x;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_x    = r_x[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_t     = {w_rem, w_x[XW-1:XW-2]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_ge    = w_t >= w_trial;
        assign n_rem   = w_ge ? RmW'(w_t - w_trial) : w_t[RmW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= {w_x[XW-3:0], 2'b00};
                r_rem[k]  <= n_rem;
                r_root[k] <= {w_root[RtW-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[RtW-1];
    assign o_root = r_root[RtW-1];
    assign o_side = r_side[RtW-1];

endmodule

`default_nettype wire

// ===== rtl/slis_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes share a
// divisor. Standalone; widths come from the parameters.
`default_nettype none

module slis_div #(
    parameter int unsigned Lanes = 1,
    parameter int unsigned QW    = 15,
    parameter int unsigned RW    = 31,
    parameter int unsigned SW    = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [Lanes-1:0][RW-1:0]     i_rem,
    input  logic [Lanes-1:0][QW-1:0]     i_num,
    input  logic [RW-1:0]                i_den,
    input  logic [SW-1:0]                i_side,
    output logic                         o_vld,
    output logic [Lanes-1:0][QW-1:0]     o_quo,
    output logic [SW-1:0]                o_side
);
    logic                     r_vld  [QW];
    logic [Lanes-1:0][RW-1:0] r_rem  [QW];
    logic [Lanes-1:0][QW-1:0] r_nq   [QW];
    logic [RW-1:0]            r_den  [QW];
    logic [SW-1:0]            r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                     w_vld;
        logic [Lanes-1:0][RW-1:0] w_rem;
        logic [Lanes-1:0][QW-1:0] w_nq;
        logic [RW-1:0]            w_den;
        logic [SW-1:0]            w_side;
        logic [Lanes-1:0][RW-1:0] n_rem;
        logic [Lanes-1:0][QW-1:0] n_nq;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = i_rem;
            assign w_nq   = i_num;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_nq   = r_nq[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
        end

        for (genvar l = 0; l < Lanes; l++) begin : g_lane
            logic [RW:0] w_t;
            logic        w_ge;

            assign w_t      = {w_rem[l], w_nq[l][QW-1]};
            assign w_ge     = w_t >= {1'b0, w_den};
            assign n_rem[l] = w_ge ? RW'(w_t - {1'b0, w_den}) : w_t[RW-1:0];
            assign n_nq[l]  = {w_nq[l][QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_nq[k]   <= n_nq;
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_nq[QW-1];
    assign o_side = r_side[QW-1];

endmodule

`default_nettype wire

// ===== rtl/spot_light_incident_scale_core.sv =====
// Top level of the spot light incident scale core: unit direction, cone falloff
// and falloff over squared distance. Depends on slis_pkg, slis_pt_if,
// slis_res_if, slis_sqrt and slis_div.
//
// Use: the light position, cone axis and the two cone cosines are written
// through the register port (i_cfg_we, i_cfg_idx, i_cfg_data) while no word is
// in flight. Each word on i_pt is a shading point; each word on o_res holds the
// direction toward the light, the falloff, the scale and a flag set when the
// point sits on the light.
// Throughput is one word per cycle while o_res is not stalled. The path from an
// accepted point to its result word on o_res is set by the
// bit-serial square root (31 stages) and the three dividers (15, 15 and 32
// stages) in series with 12 further register stages.
// The whole pipeline moves together: i_pt.ready is high when the output
// register is empty or is taken in that cycle, so a receiver stall freezes
// every stage and nothing is dropped or repeated.
// Reset clears all valid bits and loads the registers with their defaults;
// the block accepts a word in the first cycle after reset.
`default_nettype none

module spot_light_incident_scale_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slis_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [slis_pkg::CfgDataW-1:0]   i_cfg_data,
    slis_pt_if.sink                         i_pt,
    slis_res_if.source                      o_res
);
    localparam int unsigned PosW  = slis_pkg::PosW;
    localparam int unsigned AxW   = slis_pkg::AxW;
    localparam int unsigned DirW  = slis_pkg::DirW;
    localparam int unsigned FracW = slis_pkg::DirFracW;
    localparam int unsigned DiffW = slis_pkg::DiffW;
    localparam int unsigned AbsW  = slis_pkg::AbsW;
    localparam int unsigned PW    = slis_pkg::AbsPosW;
    localparam int unsigned NormW = slis_pkg::NormW;
    localparam int unsigned SqW   = slis_pkg::SqW;
    localparam int unsigned SumW  = slis_pkg::SumW;
    localparam int unsigned RootW = slis_pkg::RootW;
    localparam int unsigned AdW   = slis_pkg::AdW;
    localparam int unsigned AdSqW = slis_pkg::AdSqW;
    localparam int unsigned DdW   = slis_pkg::DdW;
    localparam int unsigned NumW  = slis_pkg::NumW;
    localparam int unsigned QW    = slis_pkg::DivQW;
    localparam int unsigned RemW  = slis_pkg::DivRemW;
    localparam int unsigned ProdW = slis_pkg::ProdW;
    localparam int unsigned C28W  = slis_pkg::C28W;
    localparam int unsigned FallW = slis_pkg::FallW;
    localparam int unsigned SQW   = slis_pkg::ScaleQW;
    localparam int unsigned ScW   = slis_pkg::ScaleW;

    function automatic logic [PW-1:0] f_lead_one(input logic [AbsW-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        for (int b = 0; b < AbsW; b++) begin
            if (v[b]) begin
                p = PW'(b);
            end
        end
        return p;
    endfunction

    // Configuration registers.
    logic signed [PosW-1:0] r_lpos [3];
    logic signed [AxW-1:0]  r_axis [3];
    logic signed [AxW-1:0]  r_cos_full;
    logic signed [AxW-1:0]  r_cos_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpos[0]  <= '0;
            r_lpos[1]  <= '0;
            r_lpos[2]  <= '0;
            r_axis[0]  <= '0;
            r_axis[1]  <= '0;
            r_axis[2]  <= slis_pkg::AxisZRst;
            r_cos_full <= slis_pkg::CosFullRst;
            r_cos_edge <= slis_pkg::CosEdgeRst;
        end else if (i_cfg_we) begin
            case (slis_pkg::t_cfg_reg'(i_cfg_idx))
                slis_pkg::CFG_LIGHT_POS_X: r_lpos[0]  <= i_cfg_data;
                slis_pkg::CFG_LIGHT_POS_Y: r_lpos[1]  <= i_cfg_data;
                slis_pkg::CFG_LIGHT_POS_Z: r_lpos[2]  <= i_cfg_data;
                slis_pkg::CFG_AXIS_X:      r_axis[0]  <= i_cfg_data[AxW-1:0];
                slis_pkg::CFG_AXIS_Y:      r_axis[1]  <= i_cfg_data[AxW-1:0];
                slis_pkg::CFG_AXIS_Z:      r_axis[2]  <= i_cfg_data[AxW-1:0];
                slis_pkg::CFG_COS_FULL:    r_cos_full <= i_cfg_data[AxW-1:0];
                slis_pkg::CFG_COS_EDGE:    r_cos_edge <= i_cfg_data[AxW-1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_vld;

    assign w_en       = !r_out_vld || o_res.ready;
    assign i_pt.ready = w_en;

    logic signed [PosW-1:0] w_pt [3];
    assign w_pt[0] = i_pt.point_x;
    assign w_pt[1] = i_pt.point_y;
    assign w_pt[2] = i_pt.point_z;

    // Valid bits of the stages kept in this module.
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld;
    logic r_g_vld, r_h_vld, r_i_vld, r_j_vld, r_k_vld;
    logic w_s_vld, w_q_vld, w_fq_vld, w_sq_vld;

    // Stage A: difference vector toward the light.
    logic [2:0][DiffW-1:0] r_a_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a_d[k] <= {r_lpos[k][PosW-1], r_lpos[k]} - {w_pt[k][PosW-1], w_pt[k]};
            end
        end
    end

    // Stage B: magnitudes and signs.
    logic [2:0][DiffW-1:0] w_b_negd;
    logic [2:0][AbsW-1:0]  w_b_abs;
    logic [2:0][AbsW-1:0]  r_b_abs;
    logic [2:0]            r_b_neg;
    logic                  r_b_big;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_b_negd[k] = DiffW'(0) - r_a_d[k];
            w_b_abs[k]  = r_a_d[k][DiffW-1] ? w_b_negd[k][AbsW-1:0] : r_a_d[k][AbsW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_abs <= w_b_abs;
            for (int k = 0; k < 3; k++) begin
                r_b_neg[k] <= r_a_d[k][DiffW-1];
            end
            r_b_big <= (|w_b_abs[0][AbsW-1:AdW]) || (|w_b_abs[1][AbsW-1:AdW])
                    || (|w_b_abs[2][AbsW-1:AdW]);
        end
    end

    // Stage C: normalize so the largest magnitude has its top bit at 29.
    logic [AbsW-1:0]       w_c_or;
    logic [PW-1:0]         w_c_sh;
    logic [2:0][AbsW-1:0]  w_c_ex;
    logic [2:0][NormW-1:0] r_c_an;
    logic [2:0][AdSqW-1:0] r_c_sqd;
    logic [2:0]            r_c_neg;
    logic                  r_c_degen;
    logic                  r_c_big;

    assign w_c_or = r_b_abs[0] | r_b_abs[1] | r_b_abs[2];
    assign w_c_sh = PW'(AbsW - 1) - f_lead_one(w_c_or);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_c_ex[k] = r_b_abs[k] << w_c_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_c_an[k]  <= w_c_ex[k][AbsW-1:AbsW-NormW];
                r_c_sqd[k] <= r_b_abs[k][AdW-1:0] * r_b_abs[k][AdW-1:0];
            end
            r_c_neg   <= r_b_neg;
            r_c_degen <= (w_c_or == '0);
            r_c_big   <= r_b_big;
        end
    end

    // Stage D: squares.
    logic [2:0][SqW-1:0]   r_d_sq;
    logic [DdW-1:0]        r_d_dd;
    logic [2:0][NormW-1:0] r_d_an;
    logic [2:0]            r_d_neg;
    logic                  r_d_degen;
    logic                  r_d_big;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d_sq[k] <= r_c_an[k] * r_c_an[k];
            end
            r_d_dd    <= DdW'(r_c_sqd[0]) + DdW'(r_c_sqd[1]) + DdW'(r_c_sqd[2]);
            r_d_an    <= r_c_an;
            r_d_neg   <= r_c_neg;
            r_d_degen <= r_c_degen;
            r_d_big   <= r_c_big;
        end
    end

    // Stage E: sum of squares.
    logic [SumW-1:0]           r_e_sum;
    slis_pkg::t_sqrt_side      r_e_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_sum        <= SumW'(r_d_sq[0]) + SumW'(r_d_sq[1]) + SumW'(r_d_sq[2]);
            r_e_side.an    <= r_d_an;
            r_e_side.neg   <= r_d_neg;
            r_e_side.degen <= r_d_degen;
            r_e_side.big   <= r_d_big;
            r_e_side.dd    <= r_d_dd;
        end
    end

    logic [RootW-1:0]                          w_s_root;
    logic [$bits(slis_pkg::t_sqrt_side)-1:0]   w_s_raw;
    slis_pkg::t_sqrt_side                      w_s_side;

    slis_sqrt #(
        .SW ($bits(slis_pkg::t_sqrt_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_e_vld),
        .i_x     (r_e_sum),
        .i_side  (r_e_side),
        .o_vld   (w_s_vld),
        .o_root  (w_s_root),
        .o_side  (w_s_raw)
    );

    assign w_s_side = slis_pkg::t_sqrt_side'(w_s_raw);

    // Stage F: rounded dividends for the direction.
    logic [2:0][NumW-1:0]  w_f_n;
    logic [2:0][RemW-1:0]  r_f_rem;
    logic [2:0][QW-1:0]    r_f_num;
    logic [RemW-1:0]       r_f_len;
    slis_pkg::t_ddiv_side  r_f_side;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_f_n[k] = {1'b0, w_s_side.an[k], {FracW{1'b0}}} + NumW'(w_s_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_f_rem[k] <= RemW'(w_f_n[k][NumW-1:QW]);
                r_f_num[k] <= w_f_n[k][QW-1:0];
            end
            r_f_len        <= w_s_root;
            r_f_side.neg   <= w_s_side.neg;
            r_f_side.degen <= w_s_side.degen;
            r_f_side.big   <= w_s_side.big;
            r_f_side.dd    <= w_s_side.dd;
        end
    end

    logic [2:0][QW-1:0]                        w_q_quo;
    logic [$bits(slis_pkg::t_ddiv_side)-1:0]   w_q_raw;
    slis_pkg::t_ddiv_side                      w_q_side;

    slis_div #(
        .Lanes (3),
        .QW    (QW),
        .RW    (RemW),
        .SW    ($bits(slis_pkg::t_ddiv_side))
    ) u_dir_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_f_vld),
        .i_rem   (r_f_rem),
        .i_num   (r_f_num),
        .i_den   (r_f_len),
        .i_side  (r_f_side),
        .o_vld   (w_q_vld),
        .o_quo   (w_q_quo),
        .o_side  (w_q_raw)
    );

    assign w_q_side = slis_pkg::t_ddiv_side'(w_q_raw);

    // Stage G: signed direction.
    logic [2:0][DirW-1:0] w_g_mag;
    logic [2:0][DirW-1:0] r_g_dir;
    logic                 r_g_degen;
    logic                 r_g_big;
    logic [DdW-1:0]       r_g_dd;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_g_mag[k] = {1'b0, w_q_quo[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                if (w_q_side.degen) begin
                    r_g_dir[k] <= '0;
                end else if (w_q_side.neg[k]) begin
                    r_g_dir[k] <= DirW'(0) - w_g_mag[k];
                end else begin
                    r_g_dir[k] <= w_g_mag[k];
                end
            end
            r_g_degen <= w_q_side.degen;
            r_g_big   <= w_q_side.big;
            r_g_dd    <= w_q_side.dd;
        end
    end

    // Stage H: products with the cone axis.
    logic signed [ProdW-1:0] r_h_prod [3];
    logic [2:0][DirW-1:0]    r_h_dir;
    logic                    r_h_degen;
    logic                    r_h_big;
    logic [DdW-1:0]          r_h_dd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_h_prod[k] <= $signed(r_g_dir[k]) * r_axis[k];
            end
            r_h_dir   <= r_g_dir;
            r_h_degen <= r_g_degen;
            r_h_big   <= r_g_big;
            r_h_dd    <= r_g_dd;
        end
    end

    // Stage I: cosine with the reversed axis in Q2.28.
    logic signed [C28W-1:0] r_i_c28;
    logic [2:0][DirW-1:0]   r_i_dir;
    logic                   r_i_degen;
    logic                   r_i_big;
    logic [DdW-1:0]         r_i_dd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_c28   <= -(C28W'(r_h_prod[0]) + C28W'(r_h_prod[1]) + C28W'(r_h_prod[2]));
            r_i_dir   <= r_h_dir;
            r_i_degen <= r_h_degen;
            r_i_big   <= r_h_big;
            r_i_dd    <= r_h_dd;
        end
    end

    // Stage J: cone tests and ramp operands.
    logic signed [C28W-1:0] w_j_full;
    logic signed [C28W-1:0] w_j_edge;
    logic signed [C28W-1:0] w_j_diff;
    logic signed [C28W-1:0] w_j_span;
    logic                   w_j_gt;
    logic                   w_j_lt;
    logic                   w_j_eq;
    logic [RemW-1:0]        r_j_rem;
    logic [QW-1:0]          r_j_num;
    logic [RemW-1:0]        r_j_den;
    slis_pkg::t_fdiv_side   r_j_side;

    assign w_j_full = $signed({{(C28W - AxW - FracW){r_cos_full[AxW-1]}}, r_cos_full,
                               {FracW{1'b0}}});
    assign w_j_edge = $signed({{(C28W - AxW - FracW){r_cos_edge[AxW-1]}}, r_cos_edge,
                               {FracW{1'b0}}});
    assign w_j_diff = r_i_c28 - w_j_edge;
    assign w_j_span = w_j_full - w_j_edge;
    assign w_j_gt   = r_i_c28 > w_j_full;
    assign w_j_lt   = r_i_c28 < w_j_edge;
    assign w_j_eq   = r_cos_full == r_cos_edge;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_rem          <= w_j_diff[RemW:1];
            r_j_num          <= {w_j_diff[0], {(QW - 1){1'b0}}};
            r_j_den          <= w_j_span[RemW-1:0];
            r_j_side.dir     <= r_i_dir;
            r_j_side.degen   <= r_i_degen;
            r_j_side.big     <= r_i_big;
            r_j_side.dd      <= r_i_dd;
            r_j_side.fix     <= w_j_gt || w_j_lt || w_j_eq;
            r_j_side.fix_one <= w_j_gt || (!w_j_lt && w_j_eq);
        end
    end

    logic [0:0][QW-1:0]                        w_fq_quo;
    logic [$bits(slis_pkg::t_fdiv_side)-1:0]   w_fq_raw;
    slis_pkg::t_fdiv_side                      w_fq_side;

    slis_div #(
        .Lanes (1),
        .QW    (QW),
        .RW    (RemW),
        .SW    ($bits(slis_pkg::t_fdiv_side))
    ) u_fall_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_j_vld),
        .i_rem   (r_j_rem),
        .i_num   (r_j_num),
        .i_den   (r_j_den),
        .i_side  (r_j_side),
        .o_vld   (w_fq_vld),
        .o_quo   (w_fq_quo),
        .o_side  (w_fq_raw)
    );

    assign w_fq_side = slis_pkg::t_fdiv_side'(w_fq_raw);

    // Stage K: falloff and the scale dividend.
    logic [FallW-1:0]      w_k_fall;
    logic [DdW-1:0]        w_k_rem;
    logic [DdW-1:0]        r_k_rem;
    logic [DdW-1:0]        r_k_den;
    slis_pkg::t_sdiv_side  r_k_side;

    always_comb begin
        if (!w_fq_side.fix) begin
            w_k_fall = w_fq_quo[0];
        end else if (w_fq_side.fix_one) begin
            w_k_fall = slis_pkg::FallOne;
        end else begin
            w_k_fall = '0;
        end
    end

    assign w_k_rem = DdW'({w_k_fall, 2'b00});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_rem        <= w_k_rem;
            r_k_den        <= w_fq_side.dd;
            r_k_side.dir   <= w_fq_side.dir;
            r_k_side.fall  <= w_k_fall;
            r_k_side.degen <= w_fq_side.degen;
            r_k_side.sat   <= w_fq_side.degen || (!w_fq_side.big && (w_k_rem >= w_fq_side.dd));
            r_k_side.zero  <= w_fq_side.big && !w_fq_side.degen;
        end
    end

    logic [0:0][SQW-1:0]                       w_sq_quo;
    logic [$bits(slis_pkg::t_sdiv_side)-1:0]   w_sq_raw;
    slis_pkg::t_sdiv_side                      w_sq_side;

    slis_div #(
        .Lanes (1),
        .QW    (SQW),
        .RW    (DdW),
        .SW    ($bits(slis_pkg::t_sdiv_side))
    ) u_scale_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_k_vld),
        .i_rem   (r_k_rem),
        .i_num   ('0),
        .i_den   (r_k_den),
        .i_side  (r_k_side),
        .o_vld   (w_sq_vld),
        .o_quo   (w_sq_quo),
        .o_side  (w_sq_raw)
    );

    assign w_sq_side = slis_pkg::t_sdiv_side'(w_sq_raw);

    // Output register.
    logic [2:0][DirW-1:0] r_out_dir;
    logic [FallW-1:0]     r_out_fall;
    logic [ScW-1:0]       r_out_scale;
    logic                 r_out_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_dir   <= w_sq_side.dir;
            r_out_fall  <= w_sq_side.fall;
            r_out_degen <= w_sq_side.degen;
            if (w_sq_side.sat) begin
                r_out_scale <= '1;
            end else if (w_sq_side.zero) begin
                r_out_scale <= '0;
            end else begin
                r_out_scale <= w_sq_quo[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_h_vld   <= 1'b0;
            r_i_vld   <= 1'b0;
            r_j_vld   <= 1'b0;
            r_k_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld   <= i_pt.valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld;
            r_e_vld   <= r_d_vld;
            r_f_vld   <= w_s_vld;
            r_g_vld   <= w_q_vld;
            r_h_vld   <= r_g_vld;
            r_i_vld   <= r_h_vld;
            r_j_vld   <= r_i_vld;
            r_k_vld   <= w_fq_vld;
            r_out_vld <= w_sq_vld;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.dir_x       = r_out_dir[0];
    assign o_res.dir_y       = r_out_dir[1];
    assign o_res.dir_z       = r_out_dir[2];
    assign o_res.falloff     = r_out_fall;
    assign o_res.light_scale = r_out_scale;
    assign o_res.degenerate  = r_out_degen;

endmodule

`default_nettype wire

// ===== rtl/slis_chk.sv =====
// Port checker of the spot light scale core and its bind to the top level.
// Depends on spot_light_incident_scale_core_defines.svh and slis_pkg.
`default_nettype none
`include "spot_light_incident_scale_core_defines.svh"

module slis_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [slis_pkg::DirW-1:0]       i_dir_x,
    input logic [slis_pkg::DirW-1:0]       i_dir_y,
    input logic [slis_pkg::DirW-1:0]       i_dir_z,
    input logic [slis_pkg::FallW-1:0]      i_falloff,
    input logic [slis_pkg::ScaleW-1:0]     i_scale,
    input logic                            i_degen
);
    logic w_out_stall;
    logic w_degen_ok;
    logic w_fall_ok;
    logic [3*slis_pkg::DirW+slis_pkg::FallW+slis_pkg::ScaleW:0] w_word;

    assign w_out_stall = i_out_valid && !i_out_ready;
    assign w_degen_ok  = (i_scale == '1) && (i_dir_x == '0) && (i_dir_y == '0)
                      && (i_dir_z == '0);
    assign w_fall_ok   = i_falloff <= slis_pkg::FallOne;
    assign w_word      = {i_dir_x, i_dir_y, i_dir_z, i_falloff, i_scale, i_degen};

    `SLIS_ASSERT(a_out_hold, w_out_stall |=> i_out_valid)
    `SLIS_ASSERT(a_out_stable, w_out_stall |=> $stable(w_word))
    `SLIS_ASSERT_MSG(a_ready_rule, i_in_ready == !w_out_stall, "input ready mismatch")
    `SLIS_ASSERT_MSG(a_degen_word, i_out_valid && i_degen |-> w_degen_ok, "bad degenerate word")
    `SLIS_ASSERT_MSG(a_fall_range, i_out_valid |-> w_fall_ok, "falloff above one")

endmodule

bind spot_light_incident_scale_core slis_chk u_slis_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_dir_x     (o_res.dir_x),
    .i_dir_y     (o_res.dir_y),
    .i_dir_z     (o_res.dir_z),
    .i_falloff   (o_res.falloff),
    .i_scale     (o_res.light_scale),
    .i_degen     (o_res.degenerate)
);

`default_nettype wire

// ===== dv/slis_tb_if.sv =====
// Testbench type of the result words of the spot light scale core.
// No dependencies; the block itself uses the RTL interfaces.
`timescale 1ns / 100ps
`default_nettype none

package slis_tb_types_pkg;
    typedef struct {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [14:0]        falloff;
        logic [31:0]        light_scale;
        logic               degenerate;
    } t_spot_result;
endpackage

`default_nettype wire

// ===== dv/spot_light_incident_scale_core_test.sv =====
// Self-checking testbench of spot_light_incident_scale_core: drives shading points
// under random stalls and compares each result word with a built-in light model.
// Depends on slis_pkg, slis_pt_if, slis_res_if, slis_tb_if.sv and the core RTL.
`timescale 1ns / 100ps
`default_nettype none

class spot_scoreboard;
    slis_tb_types_pkg::t_spot_result pending[$];
    logic signed [31:0] lpos[3];
    logic signed [15:0] axis[3];
    logic signed [15:0] cos_full, cos_edge;
    int errors;
    int checked;

    function new();
        lpos = '{0, 0, 0};
        axis = '{0, 0, 16384};
        cos_full = 14115;
        cos_edge = 14189;
        errors = 0;
        checked = 0;
    endfunction

    function void set_reg(slis_pkg::t_cfg_reg idx, logic [31:0] val);
        case (idx)
            slis_pkg::CFG_LIGHT_POS_X: lpos[0] = val;
            slis_pkg::CFG_LIGHT_POS_Y: lpos[1] = val;
            slis_pkg::CFG_LIGHT_POS_Z: lpos[2] = val;
            slis_pkg::CFG_AXIS_X:      axis[0] = val[15:0];
            slis_pkg::CFG_AXIS_Y:      axis[1] = val[15:0];
            slis_pkg::CFG_AXIS_Z:      axis[2] = val[15:0];
            slis_pkg::CFG_COS_FULL:    cos_full = val[15:0];
            default:                   cos_edge = val[15:0];
        endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
        slis_tb_types_pkg::t_spot_result r;
        longint d[3], dir[3];
        longint unsigned a[3], m, sum, len, q, fall, dd, scale;
        longint c28, full28, edge28;
        logic signed [31:0] pt[3];
        bit degen, far;
        pt = '{px, py, pz};
        m = 0;
        far = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(lpos[i]) - longint'(pt[i]);
            a[i] = d[i] < 0 ? -d[i] : d[i];
            if (a[i] > m) m = a[i];
            if (a[i] >= (64'd1 << 25)) far = 1;
            dir[i] = 0;
        end
        degen = (m == 0);
        if (!degen) begin
            while (m >= (64'd1 << 30)) begin
                m = m >> 1;
                for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
            end
            while (m < (64'd1 << 29)) begin
                m = m << 1;
                for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
            end
            sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = (a[i] * 16384 + (len >> 1)) / len;
                dir[i] = d[i] < 0 ? -longint'(q) : longint'(q);
            end
        end
        c28 = -(dir[0] * axis[0] + dir[1] * axis[1] + dir[2] * axis[2]);
        full28 = longint'(cos_full) * 16384;
        edge28 = longint'(cos_edge) * 16384;
        if (c28 > full28) fall = 16384;
        else if (c28 < edge28) fall = 0;
        else if (full28 == edge28) fall = 16384;
        else fall = (longint'(c28 - edge28) * 16384) / longint'(full28 - edge28);
        if (degen) begin
            scale = 64'hFFFF_FFFF;
        end else if (far) begin
            scale = 0;
        end else begin
            dd = 0;
            for (int i = 0; i < 3; i++) dd += (d[i] < 0 ? -d[i] : d[i]) ** 2;
            scale = (fall << 34) / dd;
            if (scale > 64'hFFFF_FFFF) scale = 64'hFFFF_FFFF;
        end
        r.dir_x = dir[0][15:0];
        r.dir_y = dir[1][15:0];
        r.dir_z = dir[2][15:0];
        r.falloff = fall[14:0];
        r.light_scale = scale[31:0];
        r.degenerate = degen;
        pending.push_back(r);
    endfunction

    function void check_result(slis_tb_types_pkg::t_spot_result got);
        slis_tb_types_pkg::t_spot_result exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result word %p", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        checked++;
        if (got.dir_x !== exp.dir_x) report("dir_x", exp.dir_x, got.dir_x);
        if (got.dir_y !== exp.dir_y) report("dir_y", exp.dir_y, got.dir_y);
        if (got.dir_z !== exp.dir_z) report("dir_z", exp.dir_z, got.dir_z);
        if (got.falloff !== exp.falloff) report("falloff", exp.falloff, got.falloff);
        if (got.light_scale !== exp.light_scale)
            report("light_scale", exp.light_scale, got.light_scale);
        if (got.degenerate !== exp.degenerate)
            report("degenerate", exp.degenerate, got.degenerate);
    endfunction

    function void report(string field, longint exp, longint act);
        $display("%0t: %s expected %0h actual %0h", $time, field, exp, act);
        errors++;
    endfunction
endclass

module spot_light_incident_scale_core_test;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [slis_pkg::CfgIdxW-1:0] i_cfg_idx = '0;
    logic [slis_pkg::CfgDataW-1:0] i_cfg_data = '0;
    bit rx_hold = 0;
    bit rx_calm = 0;
    bit tx_calm = 0;
    int sent = 0;

    slis_pt_if pt_ch();
    slis_res_if res_ch();
    spot_scoreboard sb = new();

    spot_light_incident_scale_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pt(pt_ch.sink), .o_res(res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        pt_ch.valid = 0;
        pt_ch.point_x = 0;
        pt_ch.point_y = 0;
        pt_ch.point_z = 0;
        res_ch.ready = 0;
    end

    // Receiver: random stall bursts, a long forced hold, none when calm.
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) begin
            slis_tb_types_pkg::t_spot_result w;
            w.dir_x = res_ch.dir_x;
            w.dir_y = res_ch.dir_y;
            w.dir_z = res_ch.dir_z;
            w.falloff = res_ch.falloff;
            w.light_scale = res_ch.light_scale;
            w.degenerate = res_ch.degenerate;
            sb.check_result(w);
        end
    end

    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold) begin
                res_ch.ready <= 0;
                @(posedge i_clk);
            end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                res_ch.ready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(slis_pkg::t_cfg_reg idx, logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int n;
        if (!tx_calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 5);
            pt_ch.valid <= 0;
            repeat (n) @(posedge i_clk);
        end
        pt_ch.valid <= 1;
        pt_ch.point_x <= px;
        pt_ch.point_y <= py;
        pt_ch.point_z <= pz;
        @(posedge i_clk iff pt_ch.ready);
        sb.note_point(px, py, pz);
        sent++;
    endtask

    task automatic drain();
        pt_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near_coord(logic [31:0] base);
        case ($urandom_range(0, 3))
            0: return base + $signed($urandom_range(0, 2047)) - 1024;
            1: return base + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            2: return base + $signed($urandom_range(0, 1 << 26)) - (1 << 25);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_unit();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic random_phase(int count);
        logic [31:0] px, py, pz;
        for (int k = 0; k < count; k++) begin
            px = near_coord(sb.lpos[0]);
            py = near_coord(sb.lpos[1]);
            pz = near_coord(sb.lpos[2]);
            if ($urandom_range(0, 30) == 0) begin
                px = sb.lpos[0];
                py = sb.lpos[1];
                pz = sb.lpos[2];
            end
            send_point(px, py, pz);
        end
    endtask

    initial begin
        logic [15:0] c1, c2;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: on the light, along the axis, extremes of the fields.
        send_point(0, 0, 0);
        send_point(0, 0, 32'h0001_0000);
        send_point(0, 0, 32'hFFFF_0000);
        send_point(32'h0000_8000, 0, 32'h0001_0000);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0001);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 0, 32'h7FFF_FFFF);
        send_point(0, 0, 1);
        send_point(32'hFFFF_FFFF, 1, 0);
        send_point(32'h01FF_FFFF, 0, 32'h0200_0000);
        drain();

        // Extreme light position, equal and swapped cone cosines.
        write_reg(slis_pkg::CFG_LIGHT_POS_X, 32'h7FFF_FFFF);
        write_reg(slis_pkg::CFG_LIGHT_POS_Y, 32'h8000_0000);
        write_reg(slis_pkg::CFG_LIGHT_POS_Z, 32'h0010_0000);
        write_reg(slis_pkg::CFG_AXIS_X, 16'h4000);
        write_reg(slis_pkg::CFG_AXIS_Y, 16'hC000);
        write_reg(slis_pkg::CFG_AXIS_Z, 16'h0000);
        write_reg(slis_pkg::CFG_COS_FULL, 16'd8000);
        write_reg(slis_pkg::CFG_COS_EDGE, 16'd8000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0010_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000);
        send_point(32'h7FFF_0000, 32'h8000_0000, 32'h0010_0000);
        send_point(32'h7FFF_FFFF, 32'h8001_0000, 32'h0010_0000);
        random_phase(60);
        drain();
        write_reg(slis_pkg::CFG_COS_FULL, 16'hC000);
        write_reg(slis_pkg::CFG_COS_EDGE, 16'h4000);
        random_phase(60);

        // Long receiver hold while points keep coming.
        fork
            begin
                rx_hold = 1;
                repeat (300) @(posedge i_clk);
                rx_hold = 0;
            end
            random_phase(150);
        join
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(slis_pkg::CFG_LIGHT_POS_X, $urandom);
            write_reg(slis_pkg::CFG_LIGHT_POS_Y, $urandom);
            write_reg(slis_pkg::CFG_LIGHT_POS_Z, $urandom);
            write_reg(slis_pkg::CFG_AXIS_X, rand_unit());
            write_reg(slis_pkg::CFG_AXIS_Y, rand_unit());
            write_reg(slis_pkg::CFG_AXIS_Z, rand_unit());
            c1 = rand_unit();
            c2 = rand_unit();
            if (ph == 3) begin
                c1 = 16'h4000;
                c2 = 16'hC000;
            end
            write_reg(slis_pkg::CFG_COS_FULL, ($signed(c1) > $signed(c2)) ? c1 : c2);
            write_reg(slis_pkg::CFG_COS_EDGE, ($signed(c1) > $signed(c2)) ? c2 : c1);
            if (ph == 3) begin
                rx_calm = 1;
                tx_calm = 1;
            end
            random_phase(70);
            drain();
        end

        $display("Sent %0d shading points and checked %0d result words", sent, sb.checked);
        $display("over several light, axis and cone settings with stalls on both sides.");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout after %0d points", sent);
        $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire
